// ----- rtl/core/bq_pkg.sv -----
// Shared types, constants and codes for the second-order IIR filter.
package bq_pkg;

    // Sample format and digit-serial datapath geometry.
    localparam int SAMPLE_W  = 32;
    localparam int DIG_W     = 4;
    localparam int NUM_DIG   = (SAMPLE_W + DIG_W - 1) / DIG_W;
    localparam int EXT_W     = NUM_DIG * DIG_W;

    // Coefficient format: signed Q3.28 in 32 bits.
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 28;
    localparam int NUM_COEF  = 5;

    // Configuration register widths and reset values.
    localparam int TYPE_W     = 2;
    localparam int OMEGA_W    = 17;
    localparam int DAMP_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam logic [OMEGA_W-1:0] OMEGA_MAX   = 17'd102944;
    localparam logic [OMEGA_W-1:0] OMEGA_RESET = 17'd6554;
    localparam logic [DAMP_W-1:0]  DAMP_RESET  = 24'd46341;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OMEGA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 2'd2;

    // Filter type codes; the unused code behaves as low-pass.
    localparam logic [TYPE_W-1:0] TYPE_LOWPASS  = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_NOTCH    = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_HIGHPASS = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       primed;
    } result_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  filter_type;
        logic [OMEGA_W-1:0] half_omega_dt;
        logic [DAMP_W-1:0]  damping;
    } cfg_t;

    // Coefficients in order b0, b1, b2, a1, a2, each divided by a0.
    typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_vec_t;

endpackage

// ----- rtl/core/bq_coef.sv -----
// Coefficient unit: serial products and a shared restoring divider.
module bq_coef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bq_pkg::cfg_t       cfg,
    output logic               busy,
    output bq_pkg::coef_vec_t  coef
);
    import bq_pkg::*;

    localparam int W2_W  = 34;
    localparam int XW_W  = 42;
    localparam int NUM_W = 45;
    localparam int REM_W = 44;
    localparam int QUO_W = COEF_FRAC + 3;

    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [4:0] MUL_LAST = 5'(OMEGA_W - 1);
    localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);
    localparam logic [2:0] IDX_LAST = 3'(NUM_COEF - 1);
    localparam logic signed [NUM_W-1:0] ONE = 45'sd4294967296;

    logic [2:0]         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [2:0]         idx_reg, idx_next;
    logic [OMEGA_W-1:0] mplier_reg, mplier_next;
    logic [W2_W-1:0]    mc_w_reg, mc_w_next;
    logic [XW_W-1:0]    mc_x_reg, mc_x_next;
    logic [W2_W-1:0]    w2_reg, w2_next;
    logic [XW_W-1:0]    xw2_reg, xw2_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   den_reg, den_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               neg_reg, neg_next;
    coef_vec_t          coef_reg;

    logic signed [NUM_W-1:0] w2s, xws, a0, a1n, a2n, b0, b1, b2, num, mag;
    logic [REM_W-1:0]        trial, cmpd;
    logic [QUO_W-1:0]        quo_rnd;
    logic [COEF_W-1:0]       coef_val;

    // Numerators in Q32 from the finished products and the filter type.
    always_comb
    begin
        w2s = NUM_W'(w2_reg);
        xws = NUM_W'(xw2_reg);
        a0  = ONE + xws + w2s;
        a1n = (w2s <<< 1) - (ONE <<< 1);
        a2n = ONE - xws + w2s;
        case (cfg.filter_type)
            TYPE_NOTCH:
            begin
                b0 = ONE + w2s;
                b1 = a1n;
                b2 = ONE + w2s;
            end
            TYPE_HIGHPASS:
            begin
                b0 = ONE;
                b1 = -(ONE <<< 1);
                b2 = ONE;
            end
            default:
            begin
                b0 = w2s;
                b1 = w2s <<< 1;
                b2 = w2s;
            end
        endcase
        case (idx_reg)
            3'd0:    num = b0;
            3'd1:    num = b1;
            3'd2:    num = b2;
            3'd3:    num = a1n;
            default: num = a2n;
        endcase
        mag = num[NUM_W-1] ? -num : num;
    end

    // One divider step: the first two steps give the integer bits.
    always_comb
    begin
        trial = (cnt_reg >= 5'd2) ? {rem_reg[REM_W-2:0], 1'b0} : rem_reg;
        cmpd  = (cnt_reg == 5'd0) ? {den_reg[REM_W-2:0], 1'b0} : den_reg;
    end

    // Round half away from zero to 28 fraction bits and apply the sign.
    assign quo_rnd  = (quo_reg + QUO_W'(1)) >> 1;
    assign coef_val = neg_reg ? -COEF_W'(quo_rnd) : COEF_W'(quo_rnd);

    // Sequencer for the products and the five divisions.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        mplier_next = mplier_reg;
        mc_w_next   = mc_w_reg;
        mc_x_next   = mc_x_reg;
        w2_next     = w2_reg;
        xw2_next    = xw2_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        case (state_reg)
            ST_START:
            begin
                mplier_next = cfg.half_omega_dt;
                mc_w_next   = W2_W'(cfg.half_omega_dt);
                mc_x_next   = XW_W'({cfg.damping, 1'b0});
                w2_next     = '0;
                xw2_next    = '0;
                cnt_next    = '0;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                begin
                    w2_next  = w2_reg + mc_w_reg;
                    xw2_next = xw2_reg + mc_x_reg;
                end
                mplier_next = mplier_reg >> 1;
                mc_w_next   = mc_w_reg << 1;
                mc_x_next   = mc_x_reg << 1;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                rem_next   = mag[REM_W-1:0];
                den_next   = a0[REM_W-1:0];
                neg_next   = num[NUM_W-1];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (trial >= cmpd)
                begin
                    rem_next = trial - cmpd;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                idx_next   = idx_reg + 3'd1;
                state_next = (idx_reg == IDX_LAST) ? ST_DONE : ST_LOAD;
            end
            default:
            begin
                state_next = ST_DONE;
            end
        endcase
        if (start)
        begin
            state_next = ST_START;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        mplier_reg <= mplier_next;
        mc_w_reg   <= mc_w_next;
        mc_x_reg   <= mc_x_next;
        w2_reg     <= w2_next;
        xw2_reg    <= xw2_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        if (state_reg == ST_STORE)
        begin
            coef_reg[idx_reg] <= coef_val;
        end
    end

    assign busy = (state_reg != ST_DONE);
    assign coef = coef_reg;

endmodule

// ----- rtl/core/bq_mac.sv -----
// Digit-serial multiply-accumulate, rounding, history and result register.
module bq_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               coef_busy,
    input  bq_pkg::coef_vec_t  coef,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  bq_pkg::sample_t    sample_item,
    output logic               result_valid,
    input  logic               result_ready,
    output bq_pkg::result_t    result_item
);
    import bq_pkg::*;

    localparam int ACC_W     = 41;
    localparam int PROD_W    = COEF_W + DIG_W + 2;
    localparam int TOT_W     = ACC_W + EXT_W;
    localparam int RND_W     = TOT_W - COEF_FRAC;
    localparam int DIG_CNT_W = $clog2(NUM_DIG);

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_RUN   = 2'd1;
    localparam logic [1:0] M_ROUND = 2'd2;
    localparam logic [1:0] M_FIN   = 2'd3;

    localparam logic [2:0] TERM_LAST = 3'(NUM_COEF - 1);
    localparam logic [2:0] TERM_NEG  = 3'd3;
    localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(NUM_DIG - 1);
    localparam logic signed [TOT_W-1:0] HALF =
        {{(TOT_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    localparam logic signed [RND_W-1:0] SAT_MAX =
        RND_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    localparam logic signed [RND_W-1:0] SAT_MIN = -SAT_MAX - RND_W'(1);

    logic [1:0]                 state_reg, state_next;
    logic                       started_reg;
    logic                       prime_reg;
    logic signed [SAMPLE_W-1:0] x_reg, px0_reg, px1_reg, py0_reg, py1_reg;
    logic [EXT_W-1:0]           opnd_reg [NUM_COEF];
    logic [2:0]                 term_reg;
    logic [DIG_CNT_W-1:0]       dig_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [EXT_W-1:0]           low_reg;
    logic signed [RND_W-1:0]    rnd_reg;
    logic                       res_valid_reg;
    result_t                    res_reg;

    logic                       accept, commit;
    logic [DIG_W-1:0]           dig;
    logic signed [DIG_W:0]      dig_s;
    logic signed [COEF_W:0]     coef_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    sum;
    logic signed [TOT_W-1:0]    total;
    logic signed [SAMPLE_W-1:0] y;

    assign sample_ready = (state_reg == M_IDLE) && !coef_busy;
    assign accept       = sample_valid && sample_ready;
    assign commit       = (state_reg == M_FIN) && (!res_valid_reg || result_ready);

    // One digit of one term times its coefficient; the top digit is signed.
    always_comb
    begin
        dig    = opnd_reg[term_reg][DIG_W-1:0];
        dig_s  = (dig_reg == DIG_LAST) ? {dig[DIG_W-1], dig} : {1'b0, dig};
        coef_s = (COEF_W+1)'($signed(coef[term_reg]));
        if (term_reg >= TERM_NEG)
        begin
            coef_s = -coef_s;
        end
        prod = PROD_W'(dig_s) * PROD_W'(coef_s);
        sum  = acc_reg + ACC_W'(prod);
    end

    // Round half up to the sample format and saturate, or pass a priming sample.
    assign total = $signed({acc_reg, low_reg});
    always_comb
    begin
        if (prime_reg)
        begin
            y = x_reg;
        end
        else if (rnd_reg > SAT_MAX)
        begin
            y = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (rnd_reg < SAT_MIN)
        begin
            y = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            y = rnd_reg[SAMPLE_W-1:0];
        end
    end

    // Item sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (accept)
                begin
                    state_next = (sample_item.restart || !started_reg) ? M_FIN : M_RUN;
                end
            end
            M_RUN:
            begin
                if (term_reg == TERM_LAST && dig_reg == DIG_LAST)
                begin
                    state_next = M_ROUND;
                end
            end
            M_ROUND:
            begin
                state_next = M_FIN;
            end
            default:
            begin
                if (commit)
                begin
                    state_next = M_IDLE;
                end
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= M_IDLE;
            started_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            term_reg      <= '0;
            dig_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                started_reg   <= 1'b1;
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                term_reg <= '0;
                dig_reg  <= '0;
            end
            else if (state_reg == M_RUN)
            begin
                if (term_reg == TERM_LAST)
                begin
                    term_reg <= '0;
                    dig_reg  <= dig_reg + DIG_CNT_W'(1);
                end
                else
                begin
                    term_reg <= term_reg + 3'd1;
                end
            end
        end
    end

    // Datapath: operand shift lines, accumulator and history.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg       <= sample_item.sample;
            prime_reg   <= sample_item.restart || !started_reg;
            acc_reg     <= '0;
            opnd_reg[0] <= EXT_W'(sample_item.sample);
            opnd_reg[1] <= EXT_W'(px0_reg);
            opnd_reg[2] <= EXT_W'(px1_reg);
            opnd_reg[3] <= EXT_W'(py0_reg);
            opnd_reg[4] <= EXT_W'(py1_reg);
        end
        else if (state_reg == M_RUN)
        begin
            if (term_reg == TERM_LAST)
            begin
                acc_reg <= sum >>> DIG_W;
                low_reg <= {sum[DIG_W-1:0], low_reg[EXT_W-1:DIG_W]};
                for (int i = 0; i < NUM_COEF; i++)
                begin
                    opnd_reg[i] <= opnd_reg[i] >> DIG_W;
                end
            end
            else
            begin
                acc_reg <= sum;
            end
        end
        if (state_reg == M_ROUND)
        begin
            rnd_reg <= RND_W'((total + HALF) >>> COEF_FRAC);
        end
        if (commit)
        begin
            res_reg.filtered <= y;
            res_reg.primed   <= prime_reg;
            if (prime_reg)
            begin
                px0_reg <= x_reg;
                px1_reg <= x_reg;
                py0_reg <= x_reg;
                py1_reg <= x_reg;
            end
            else
            begin
                px0_reg <= x_reg;
                px1_reg <= px0_reg;
                py0_reg <= y;
                py1_reg <= py0_reg;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_reg;

    // A priming item passes its sample straight through.
    a_prime_pass: assert property (@(posedge clk) disable iff (!rst_n)
        commit && prime_reg |=> result_item.filtered == $past(x_reg) && result_item.primed)
        else $error("priming item did not pass its sample through");

    // Every committed item leaves the filter started.
    a_started: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> started_reg)
        else $error("filter not started after a committed item");

    // A new result only appears out of the final state.
    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == M_FIN)
        else $error("result appeared outside the final state");

    // The last digit of the last term hands over to rounding.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_RUN && term_reg == TERM_LAST && dig_reg == DIG_LAST
        |=> state_reg == M_ROUND)
        else $error("accumulation did not end on the last digit");

endmodule

// ----- rtl/core/second_order_iir_filter.sv -----
// Top level of the second-order IIR filter: configuration registers and units.
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_ready  sample_item (sample, restart)
//  result    out        result_valid / result_ready  result_item (filtered, primed)
//  config    in         cfg_write                    cfg_index, cfg_data
//
// A filtered item is accepted, then its 5 terms of 8 digits of 4 bits pass
// through one 5 x 33 multiplier, then it is rounded and committed.
// A priming item goes from acceptance straight to commit.
// After reset and after each write to a known register the coefficient unit runs
// (17 serial product steps, then per coefficient a load, one divider step per
// quotient bit and a store); no item is accepted meanwhile.
// A stalled result holds in the output register while the next item computes.
module second_order_iir_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  bq_pkg::sample_t                 sample_item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output bq_pkg::result_t                 result_item,
    input  logic                            cfg_write,
    input  logic [bq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bq_pkg::*;

    cfg_t              cfg_reg;
    logic              start_reg;
    logic              coef_busy;
    coef_vec_t         coef;
    logic [OMEGA_W-1:0] omega_in;

    // The frequency register saturates at a quarter turn.
    assign omega_in = (cfg_data[OMEGA_W-1:0] > OMEGA_MAX) ? OMEGA_MAX
                                                          : cfg_data[OMEGA_W-1:0];

    // Register writes; a write to a known register restarts the coefficients.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_type   <= TYPE_LOWPASS;
            cfg_reg.half_omega_dt <= OMEGA_RESET;
            cfg_reg.damping       <= DAMP_RESET;
            start_reg             <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TYPE:
                    begin
                        cfg_reg.filter_type <= cfg_data[TYPE_W-1:0];
                        start_reg           <= 1'b1;
                    end
                    REG_OMEGA:
                    begin
                        cfg_reg.half_omega_dt <= omega_in;
                        start_reg             <= 1'b1;
                    end
                    REG_DAMP:
                    begin
                        cfg_reg.damping <= cfg_data[DAMP_W-1:0];
                        start_reg       <= 1'b1;
                    end
                    default:
                    begin
                        start_reg <= 1'b0;
                    end
                endcase
            end
            else
            begin
                start_reg <= 1'b0;
            end
        end
    end

    // Coefficient unit; busy also covers a write, and the cycle after a known write.
    bq_coef u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .cfg   (cfg_reg),
        .busy  (coef_busy),
        .coef  (coef)
    );

    bq_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef_busy    (coef_busy || start_reg || cfg_write),
        .coef         (coef),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule
